/* design/kgm_pkg.sv */
// Shared widths, constants and types for the keyed group mean block.
package kgm_pkg;

   localparam int DAY_W   = 16;
   localparam int HOUR_W  = 5;
   localparam int TEMP_W  = 11;
   localparam int HUM_W   = 7;
   localparam int COUNT_W = 12;
   localparam int TSUM_W  = 24;
   localparam int HSUM_W  = 19;
   localparam int STEP_W  = 5;

   localparam logic [COUNT_W-1:0] MAX_GROUP_COUNT = COUNT_W'(4095);
   localparam logic [STEP_W-1:0]  STEP_LAST       = STEP_W'(TSUM_W - 1);
   localparam logic [STEP_W-1:0]  HSUM_STEPS      = STEP_W'(HSUM_W);

   typedef struct packed {
      logic load;
      logic step;
   } ser_ctrl_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_OPEN = 6'b000010,
      ST_ADD  = 6'b000100,
      ST_WAIT = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_EMIT = 6'b100000
   } state_type;

endpackage

/* design/kgm_serial_acc.sv */
// Bit-serial accumulators for the temperature and humidity sums of the open group.
module kgm_serial_acc import kgm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  ser_ctrl_type              ctrl,
   input  logic                      clear,
   input  logic [STEP_W-1:0]         step_idx,
   input  logic signed [TEMP_W-1:0]  temperature,
   input  logic [HUM_W-1:0]          humidity,
   output logic signed [TSUM_W-1:0]  temp_sum,
   output logic [HSUM_W-1:0]         hum_sum
);

   logic [TSUM_W-1:0] t_sum_ff, t_sum_in;
   logic [TSUM_W-1:0] t_add_ff, t_add_in;
   logic              t_carry_ff, t_carry_in;
   logic [HSUM_W-1:0] h_sum_ff, h_sum_in;
   logic [HSUM_W-1:0] h_add_ff, h_add_in;
   logic              h_carry_ff, h_carry_in;
   logic              t_bit, h_bit, h_active;

   assign t_bit    = t_sum_ff[0] ^ t_add_ff[0] ^ t_carry_ff;
   assign h_bit    = h_sum_ff[0] ^ h_add_ff[0] ^ h_carry_ff;
   assign h_active = step_idx < HSUM_STEPS;

   always_comb begin
      t_sum_in   = t_sum_ff;
      t_add_in   = t_add_ff;
      t_carry_in = t_carry_ff;
      h_sum_in   = h_sum_ff;
      h_add_in   = h_add_ff;
      h_carry_in = h_carry_ff;
      if (clear) begin
         t_sum_in = '0;
         h_sum_in = '0;
      end else if (ctrl.load) begin
         t_add_in   = {{(TSUM_W-TEMP_W){temperature[TEMP_W-1]}}, temperature};
         h_add_in   = {{(HSUM_W-HUM_W){1'b0}}, humidity};
         t_carry_in = 1'b0;
         h_carry_in = 1'b0;
      end else if (ctrl.step) begin
         t_sum_in   = {t_bit, t_sum_ff[TSUM_W-1:1]};
         t_add_in   = {1'b0, t_add_ff[TSUM_W-1:1]};
         t_carry_in = (t_sum_ff[0] & t_add_ff[0]) | (t_carry_ff & (t_sum_ff[0] ^ t_add_ff[0]));
         if (h_active) begin
            h_sum_in   = {h_bit, h_sum_ff[HSUM_W-1:1]};
            h_add_in   = {1'b0, h_add_ff[HSUM_W-1:1]};
            h_carry_in = (h_sum_ff[0] & h_add_ff[0]) |
                         (h_carry_ff & (h_sum_ff[0] ^ h_add_ff[0]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_sum_ff <= '0;
         h_sum_ff <= '0;
      end else begin
         t_sum_ff <= t_sum_in;
         h_sum_ff <= h_sum_in;
      end
      t_add_ff   <= t_add_in;
      t_carry_ff <= t_carry_in;
      h_add_ff   <= h_add_in;
      h_carry_ff <= h_carry_in;
   end

   assign temp_sum = t_sum_ff;
   assign hum_sum  = h_sum_ff;

endmodule

/* design/kgm_serial_div.sv */
// Radix-2 restoring dividers that form both group means one quotient bit per cycle.
module kgm_serial_div import kgm_pkg::*; (
   input  logic                      clock,
   input  ser_ctrl_type              ctrl,
   input  logic [STEP_W-1:0]         step_idx,
   input  logic signed [TSUM_W-1:0]  temp_sum,
   input  logic [HSUM_W-1:0]         hum_sum,
   input  logic [COUNT_W-1:0]        divisor,
   output logic signed [TEMP_W-1:0]  mean_temperature,
   output logic [HUM_W-1:0]          mean_humidity
);

   logic [COUNT_W-1:0] div_ff, div_in;
   logic               t_neg_ff, t_neg_in;
   logic [COUNT_W-1:0] t_rem_ff, t_rem_in;
   logic [TSUM_W-1:0]  t_quo_ff, t_quo_in;
   logic [COUNT_W-1:0] h_rem_ff, h_rem_in;
   logic [HSUM_W-1:0]  h_quo_ff, h_quo_in;
   logic [COUNT_W:0]   t_shift, h_shift, div_wide;
   logic               t_ge, h_ge;
   logic [COUNT_W:0]   t_diff, h_diff;
   logic [TSUM_W-1:0]  t_mag;
   logic [TEMP_W-1:0]  t_low;

   assign div_wide = {1'b0, div_ff};
   assign t_shift  = {t_rem_ff, t_quo_ff[TSUM_W-1]};
   assign h_shift  = {h_rem_ff, h_quo_ff[HSUM_W-1]};
   assign t_ge     = t_shift >= div_wide;
   assign h_ge     = h_shift >= div_wide;
   assign t_diff   = t_shift - div_wide;
   assign h_diff   = h_shift - div_wide;
   assign t_mag    = temp_sum[TSUM_W-1] ? (~temp_sum + TSUM_W'(1)) : temp_sum;

   always_comb begin
      div_in   = div_ff;
      t_neg_in = t_neg_ff;
      t_rem_in = t_rem_ff;
      t_quo_in = t_quo_ff;
      h_rem_in = h_rem_ff;
      h_quo_in = h_quo_ff;
      if (ctrl.load) begin
         div_in   = divisor;
         t_neg_in = temp_sum[TSUM_W-1];
         t_rem_in = '0;
         t_quo_in = t_mag;
         h_rem_in = '0;
         h_quo_in = hum_sum;
      end else if (ctrl.step) begin
         t_rem_in = t_ge ? t_diff[COUNT_W-1:0] : t_shift[COUNT_W-1:0];
         t_quo_in = {t_quo_ff[TSUM_W-2:0], t_ge};
         if (step_idx < HSUM_STEPS) begin
            h_rem_in = h_ge ? h_diff[COUNT_W-1:0] : h_shift[COUNT_W-1:0];
            h_quo_in = {h_quo_ff[HSUM_W-2:0], h_ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      div_ff   <= div_in;
      t_neg_ff <= t_neg_in;
      t_rem_ff <= t_rem_in;
      t_quo_ff <= t_quo_in;
      h_rem_ff <= h_rem_in;
      h_quo_ff <= h_quo_in;
   end

   assign t_low            = t_quo_ff[TEMP_W-1:0];
   assign mean_temperature = t_neg_ff ? (~t_low + TEMP_W'(1)) : t_low;
   assign mean_humidity    = h_quo_ff[HUM_W-1:0];

endmodule

/* design/keyed_group_mean_core.sv */
// Top level of the keyed group mean block: control sequencer, group state and result register.
//
// Readings enter on the req_ channel (valid/ready); a transaction is accepted when both
// are high. Consecutive readings with an equal key form a group; the key is the day, or
// the day and hour when csr_group_by_hour is 1, written through the csr_ channel; the user
// must write it only while the block is idle, and the block does not enforce this. A key
// change closes the open group, and a final reading flushes its group. Each closed group
// leaves on the rsp_ channel with its key, truncated means and count; rsp_last_of_run
// marks the last result caused by one reading. A reading that closes nothing is accepted,
// then opens the group or tests the count limit, and below the limit runs the serial adders.
// Each closed group claims the result register, runs the serial dividers, loads the result.
// The 24-bit temperature sum sets both serial loops. req_ready is high only while the
// sequencer is idle; a new reading is taken while a result still waits in the register.
// When the receiver stalls, a finished group waits in the sequencer until the result
// register is free. Synchronous reset empties the group, clears the result valid flag and
// sets daily grouping.
module keyed_group_mean_core import kgm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [DAY_W-1:0]          req_day_code,
   input  logic [HOUR_W-1:0]         req_hour_of_day,
   input  logic signed [TEMP_W-1:0]  req_temperature,
   input  logic [HUM_W-1:0]          req_humidity,
   input  logic                      req_final_reading,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [DAY_W-1:0]          rsp_group_day,
   output logic [HOUR_W-1:0]         rsp_group_hour,
   output logic signed [TEMP_W-1:0]  rsp_mean_temperature,
   output logic [HUM_W-1:0]          rsp_mean_humidity,
   output logic [COUNT_W-1:0]        rsp_reading_count,
   output logic                      rsp_count_saturated,
   output logic                      rsp_last_of_run,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic                      csr_group_by_hour
);

   state_type state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                closing_ff, closing_in;
   logic                by_hour_ff;
   logic [DAY_W-1:0]    day_ff;
   logic [HOUR_W-1:0]   hour_ff;
   logic [TEMP_W-1:0]   temp_ff;
   logic [HUM_W-1:0]    hum_ff;
   logic                final_ff;
   logic [DAY_W-1:0]    cur_day_ff, cur_day_in;
   logic [HOUR_W-1:0]   cur_hour_ff, cur_hour_in;
   logic                open_ff, open_in;
   logic                ovf_ff, ovf_in;
   logic [COUNT_W-1:0]  size_ff, size_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [DAY_W-1:0]    rsp_day_ff;
   logic [HOUR_W-1:0]   rsp_hour_ff;
   logic [TEMP_W-1:0]   rsp_temp_ff;
   logic [HUM_W-1:0]    rsp_hum_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_sat_ff;
   logic                rsp_last_ff;
   logic                req_take, same_key, at_limit;
   ser_ctrl_type        acc_ctrl, div_ctrl;
   logic                acc_clear;
   logic signed [TSUM_W-1:0] temp_sum;
   logic [HSUM_W-1:0]   hum_sum;
   logic signed [TEMP_W-1:0] mean_temp;
   logic [HUM_W-1:0]    mean_hum;

   assign req_ready = state_ff == ST_IDLE;
   assign csr_ready = 1'b1;
   assign req_take  = req_valid && req_ready;
   assign same_key  = (req_day_code == cur_day_ff) &&
                      (!by_hour_ff || (req_hour_of_day == cur_hour_ff));
   assign at_limit  = size_ff >= MAX_GROUP_COUNT;

   assign acc_ctrl.load = (state_ff == ST_OPEN) && !at_limit;
   assign acc_ctrl.step = state_ff == ST_ADD;
   assign acc_clear     = state_ff == ST_EMIT;
   assign div_ctrl.load = (state_ff == ST_WAIT) && !rsp_valid_ff;
   assign div_ctrl.step = state_ff == ST_DIV;

   kgm_serial_acc u_acc (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (acc_ctrl),
      .clear       (acc_clear),
      .step_idx    (step_ff),
      .temperature (temp_ff),
      .humidity    (hum_ff),
      .temp_sum    (temp_sum),
      .hum_sum     (hum_sum)
   );

   kgm_serial_div u_div (
      .clock            (clock),
      .ctrl             (div_ctrl),
      .step_idx         (step_ff),
      .temp_sum         (temp_sum),
      .hum_sum          (hum_sum),
      .divisor          (size_ff),
      .mean_temperature (mean_temp),
      .mean_humidity    (mean_hum)
   );

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      closing_in   = closing_ff;
      cur_day_in   = cur_day_ff;
      cur_hour_in  = cur_hour_ff;
      open_in      = open_ff;
      ovf_in       = ovf_ff;
      size_in      = size_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               closing_in = open_ff && !same_key;
               state_in   = (open_ff && !same_key) ? ST_WAIT : ST_OPEN;
            end
         end
         ST_OPEN: begin
            if (!open_ff) begin
               open_in     = 1'b1;
               cur_day_in  = day_ff;
               cur_hour_in = by_hour_ff ? hour_ff : '0;
            end
            step_in = '0;
            if (at_limit) begin
               ovf_in   = 1'b1;
               state_in = final_ff ? ST_WAIT : ST_IDLE;
            end else begin
               size_in  = size_ff + COUNT_W'(1);
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               step_in  = '0;
               state_in = final_ff ? ST_WAIT : ST_IDLE;
            end
         end
         ST_WAIT: begin
            step_in = '0;
            if (!rsp_valid_ff) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               step_in  = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            open_in      = 1'b0;
            ovf_in       = 1'b0;
            size_in      = '0;
            closing_in   = 1'b0;
            state_in     = closing_ff ? ST_OPEN : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         closing_ff   <= 1'b0;
         by_hour_ff   <= 1'b0;
         cur_day_ff   <= '0;
         cur_hour_ff  <= '0;
         open_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         size_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         closing_ff   <= closing_in;
         cur_day_ff   <= cur_day_in;
         cur_hour_ff  <= cur_hour_in;
         open_ff      <= open_in;
         ovf_ff       <= ovf_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            by_hour_ff <= csr_group_by_hour;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         day_ff   <= req_day_code;
         hour_ff  <= req_hour_of_day;
         temp_ff  <= req_temperature;
         hum_ff   <= req_humidity;
         final_ff <= req_final_reading;
      end
      if (state_ff == ST_EMIT) begin
         rsp_day_ff   <= cur_day_ff;
         rsp_hour_ff  <= cur_hour_ff;
         rsp_temp_ff  <= mean_temp;
         rsp_hum_ff   <= mean_hum;
         rsp_count_ff <= size_ff;
         rsp_sat_ff   <= ovf_ff;
         rsp_last_ff  <= closing_ff ? !final_ff : 1'b1;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_group_day        = rsp_day_ff;
   assign rsp_group_hour       = rsp_hour_ff;
   assign rsp_mean_temperature = rsp_temp_ff;
   assign rsp_mean_humidity    = rsp_hum_ff;
   assign rsp_reading_count    = rsp_count_ff;
   assign rsp_count_saturated  = rsp_sat_ff;
   assign rsp_last_of_run      = rsp_last_ff;

endmodule

/* design/kgm_checker.sv */
// Port-level assertion checker for the keyed group mean block and its bind statement.
module kgm_checker import kgm_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [COUNT_W-1:0]        rsp_reading_count,
   input logic                      rsp_count_saturated
);

   // A result transaction that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the transaction completed");

   // Every reported group holds at least one reading.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_reading_count != '0)
      else $error("result reports an empty group");

   // A saturated group always reports the full count.
   a_sat_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_count_saturated |-> rsp_reading_count == MAX_GROUP_COUNT)
      else $error("saturated group reports a count below the limit");

   // The block works on one reading at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("a second reading was offered ready directly after acceptance");

endmodule

bind keyed_group_mean_core kgm_checker u_kgm_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_reading_count   (rsp_reading_count),
   .rsp_count_saturated (rsp_count_saturated)
);
